// ===== design/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the sonar moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

    // Fixed field widths
    localparam int CH_W      = 2;
    localparam int RANGE_W   = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int NUM_REGS  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CH0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CH1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CH2 = 2'd2;
    localparam logic [RANGE_W-1:0]   RANGE_MAX         = 16'hFFFF;

    // Output queue sizing
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_CW    = 4;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [RANGE_W-1:0] range_mm;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [RANGE_W-1:0] out_range_mm;
        logic               over_range;
    } out_word_t;

    // Per-channel window state seen by an incoming sample
    typedef struct packed {
        logic first;    // very first sample of the channel: running sum starts at zero
        logic full;     // window already holds WINDOW samples
    } win_status_t;

endpackage

// ===== design/sma_window.sv =====
// ----------------------------------------------------------------------------
// sma_window
// Sample window memory with per-channel write pointer and fill flag.
// ----------------------------------------------------------------------------
module sma_window
    import sma_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 3,
    localparam int PTR_W   = $clog2(WINDOW),
    localparam int CIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               acc,
    input  logic [CIDX_W-1:0]  ch_idx,
    input  logic [RANGE_W-1:0] sample,
    output win_status_t        status,
    output logic [RANGE_W-1:0] old_sample
);

    localparam int WMEM_DEPTH = 1 << (CIDX_W + PTR_W);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    logic [PTR_W-1:0]   ptr_reg [CHANNELS];
    logic               full_reg [CHANNELS];
    logic [PTR_W-1:0]   ptr_cur;
    logic               full_cur;
    logic [PTR_W-1:0]   ptr_next;
    logic               full_next;
    logic [RANGE_W-1:0] win_mem [WMEM_DEPTH];
    logic [RANGE_W-1:0] old_sample_reg;

    // Current channel's pointer; the oldest slot once the window is full
    always_comb
    begin
        ptr_cur   = ptr_reg[ch_idx];
        full_cur  = full_reg[ch_idx];
        ptr_next  = (ptr_cur == PTR_LAST) ? '0 : ptr_cur + 1'b1;
        full_next = full_cur | (ptr_cur == PTR_LAST);
    end

    assign status.first = !full_cur && (ptr_cur == '0);
    assign status.full  = full_cur;

    // Pointer and fill flag update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ptr_reg[i]  <= '0;
                full_reg[i] <= 1'b0;
            end
        end
        else if (acc)
        begin
            ptr_reg[ch_idx]  <= ptr_next;
            full_reg[ch_idx] <= full_next;
        end
    end

    // Read-first window memory: old sample out, new sample in
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            old_sample_reg            <= win_mem[{ch_idx, ptr_cur}];
            win_mem[{ch_idx, ptr_cur}] <= sample;
        end
    end

    assign old_sample = old_sample_reg;

endmodule

// ===== design/sma_sum.sv =====
// ----------------------------------------------------------------------------
// sma_sum
// Running sum memory: read one cycle, update and write back the next,
// with forwarding of the last written sum.
// ----------------------------------------------------------------------------
module sma_sum
    import sma_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 3,
    localparam int PTR_W   = $clog2(WINDOW),
    localparam int CIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int SUM_W   = RANGE_W + PTR_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [CIDX_W-1:0]  rd_ch,
    input  logic               upd_valid,
    input  logic [CIDX_W-1:0]  upd_ch,
    input  win_status_t        upd_status,
    input  logic [RANGE_W-1:0] upd_sample,
    input  logic [RANGE_W-1:0] upd_old,
    output logic [SUM_W-1:0]   new_sum
);

    localparam int SMEM_DEPTH = 1 << CIDX_W;

    logic [SUM_W-1:0]  sum_mem [SMEM_DEPTH];
    logic [SUM_W-1:0]  rd_data_reg;
    logic              wb_valid_reg;
    logic [CIDX_W-1:0] wb_ch_reg;
    logic [SUM_W-1:0]  wb_sum_reg;
    logic [SUM_W-1:0]  base_sum;
    logic [SUM_W-1:0]  drop;

    // Pick the current sum: zero on a fresh channel, else forwarded or stored
    always_comb
    begin
        if (upd_status.first)
            base_sum = '0;
        else if (wb_valid_reg && (wb_ch_reg == upd_ch))
            base_sum = wb_sum_reg;
        else
            base_sum = rd_data_reg;
        drop    = upd_status.full ? SUM_W'(upd_old) : '0;
        new_sum = base_sum - drop + SUM_W'(upd_sample);
    end

    // Sum memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= sum_mem[rd_ch];
        if (upd_valid)
            sum_mem[upd_ch] <= new_sum;
    end

    // Forwarding register for a write landing on the same edge as a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else
            wb_valid_reg <= upd_valid;
    end

    always_ff @(posedge clk)
    begin
        wb_ch_reg  <= upd_ch;
        wb_sum_reg <= new_sum;
    end

endmodule

// ===== design/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// Two-stage divide of the window sum by WINDOW: reciprocal multiply,
// then one correction step; selects mean or raw sample.
// ----------------------------------------------------------------------------
module sma_div
    import sma_pkg::*;
#(
    parameter int WINDOW  = 8,
    localparam int PTR_W  = $clog2(WINDOW),
    localparam int SUM_W  = RANGE_W + PTR_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [SUM_W-1:0]   in_sum,
    input  logic [CH_W-1:0]    in_ch,
    input  logic [RANGE_W-1:0] in_sample,
    input  logic               in_over,
    output logic               push,
    output out_word_t          push_word,
    output logic [1:0]         busy
);

    // floor(2^SUM_W / WINDOW): estimate is low by at most one
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

    logic               a_valid_reg;
    logic [SUM_W-1:0]   a_sum_reg;
    logic [CH_W-1:0]    a_ch_reg;
    logic [RANGE_W-1:0] a_sample_reg;
    logic               a_over_reg;

    logic               b_valid_reg;
    logic [SUM_W-1:0]   b_qest_reg;
    logic [SUM_W-1:0]   b_sum_reg;
    logic [CH_W-1:0]    b_ch_reg;
    logic [RANGE_W-1:0] b_sample_reg;
    logic               b_over_reg;

    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0]   qest_next;
    logic [SUM_W-1:0]   back_mul;
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   quot;

    // Stage A: reciprocal product
    assign prod      = a_sum_reg * RECIP;
    assign qest_next = prod[2*SUM_W-1:SUM_W];

    // Stage B: remainder check and increment
    always_comb
    begin
        back_mul = SUM_W'(b_qest_reg * WIN_C);
        rem      = b_sum_reg - back_mul;
        quot     = (rem >= WIN_C) ? b_qest_reg + 1'b1 : b_qest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_vld;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sum_reg    <= in_sum;
        a_ch_reg     <= in_ch;
        a_sample_reg <= in_sample;
        a_over_reg   <= in_over;
        b_qest_reg   <= qest_next;
        b_sum_reg    <= a_sum_reg;
        b_ch_reg     <= a_ch_reg;
        b_sample_reg <= a_sample_reg;
        b_over_reg   <= a_over_reg;
    end

    // Result word
    assign push                   = b_valid_reg;
    assign push_word.out_channel  = b_ch_reg;
    assign push_word.out_range_mm = b_over_reg ? b_sample_reg : quot[RANGE_W-1:0];
    assign push_word.over_range   = b_over_reg;
    assign busy                   = {1'b0, a_valid_reg} + {1'b0, b_valid_reg};

endmodule

// ===== design/sma_ofifo.sv =====
// ----------------------------------------------------------------------------
// sma_ofifo
// Output queue holding finished result words until the sink takes them.
// ----------------------------------------------------------------------------
module sma_ofifo
    import sma_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  out_word_t           push_word,
    output logic                out_valid,
    input  logic                out_stall,
    output out_word_t           out_data,
    output logic [OFIFO_CW-1:0] count
);

    out_word_t           q_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg;
    logic [OFIFO_AW-1:0] rd_ptr_reg;
    logic [OFIFO_CW-1:0] count_reg;
    logic [OFIFO_CW-1:0] count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = q_mem[rd_ptr_reg];
    assign count     = count_reg;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== design/sonar_moving_average.sv =====
// Path: stage 1 registers, divider stages A and B, then the output queue to out_valid.
// Throughput: one sample per cycle while in_stall is low, set by the running-sum memory
// read-modify-write, which keeps pace through forwarding of the last written sum.
// Reset: clears window pointers, fill flags, output queue and sets max ranges to 65535;
// window and sum memories are not cleared (a channel's first sample starts its sum at 0).
// ----------------------------------------------------------------------------
// sonar_moving_average
// Per-channel boxcar average of sonar range samples with over-range bypass.
// ----------------------------------------------------------------------------
module sonar_moving_average
    import sma_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data
);

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W  = RANGE_W + PTR_W;

    logic [RANGE_W-1:0]  max_range_reg [NUM_REGS];
    logic                acc;
    logic [CIDX_W-1:0]   ch_idx;
    logic [RANGE_W-1:0]  limit;
    win_status_t         status;
    logic [RANGE_W-1:0]  old_sample;
    logic [SUM_W-1:0]    new_sum;
    logic                push;
    out_word_t           push_word;
    logic [1:0]          div_busy;
    logic [OFIFO_CW-1:0] q_count;
    logic [OFIFO_CW-1:0] occupancy;

    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [CIDX_W-1:0]   s1_idx_reg;
    logic [RANGE_W-1:0]  s1_sample_reg;
    logic                s1_over_reg;
    win_status_t         s1_status_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg[REG_MAX_RANGE_CH0] <= RANGE_MAX;
            max_range_reg[REG_MAX_RANGE_CH1] <= RANGE_MAX;
            max_range_reg[REG_MAX_RANGE_CH2] <= RANGE_MAX;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_RANGE_CH0: max_range_reg[REG_MAX_RANGE_CH0] <= cfg_data;
                REG_MAX_RANGE_CH1: max_range_reg[REG_MAX_RANGE_CH1] <= cfg_data;
                REG_MAX_RANGE_CH2: max_range_reg[REG_MAX_RANGE_CH2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Intake: stall on queue space counting words still in the pipeline
    assign occupancy = q_count + OFIFO_CW'(s1_valid_reg) + OFIFO_CW'(div_busy);
    assign in_stall  = (occupancy >= OFIFO_CW'(OFIFO_DEPTH));
    assign acc       = in_valid && !in_stall && (int'(in_data.channel) < CHANNELS);
    assign ch_idx    = CIDX_W'(in_data.channel);

    // Channels without a register never go over range
    always_comb
    begin
        if (int'(in_data.channel) < NUM_REGS)
            limit = max_range_reg[in_data.channel];
        else
            limit = RANGE_MAX;
    end

    sma_window #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .ch_idx     (ch_idx),
        .sample     (in_data.range_mm),
        .status     (status),
        .old_sample (old_sample)
    );

    // Stage 1 registers, aligned with memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg     <= in_data.channel;
        s1_idx_reg    <= ch_idx;
        s1_sample_reg <= in_data.range_mm;
        s1_over_reg   <= (in_data.range_mm > limit);
        s1_status_reg <= status;
    end

    sma_sum #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (acc),
        .rd_ch      (ch_idx),
        .upd_valid  (s1_valid_reg),
        .upd_ch     (s1_idx_reg),
        .upd_status (s1_status_reg),
        .upd_sample (s1_sample_reg),
        .upd_old    (old_sample),
        .new_sum    (new_sum)
    );

    // Only samples arriving on a full window produce a word
    sma_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (s1_valid_reg && s1_status_reg.full),
        .in_sum    (new_sum),
        .in_ch     (s1_ch_reg),
        .in_sample (s1_sample_reg),
        .in_over   (s1_over_reg),
        .push      (push),
        .push_word (push_word),
        .busy      (div_busy)
    );

    sma_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .count     (q_count)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sonar_moving_average. A queue of range samples
// feeds a bursty driver. A scoreboard model of the per-channel windows
// predicts each result word, and a monitor under random backpressure
// compares it field by field. Max-range limits change between phases,
// and only while the block is drained.
// ----------------------------------------------------------------------------
module testbench
    import sma_pkg::*;
();

    localparam int WINDOW      = 8;
    localparam int CHANNELS    = 3;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 230;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    // no register behind this index: writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RANGE_W-1:0]   cfg_data = '0;

    // samples waiting to be driven, and result words still owed by the block
    in_word_t  sample_q[$];
    out_word_t avg_expected[$];

    // scoreboard copy of the window state and the limits
    logic [RANGE_W-1:0] win_mem [CHANNELS][WINDOW];
    int unsigned        fill_cnt [CHANNELS];
    int unsigned        run_sum [CHANNELS];
    int unsigned        oldest_pos [CHANNELS];
    logic [RANGE_W-1:0] limit_mm [NUM_REGS];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    sonar_moving_average #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** sonar_moving_average: FAILED **");
            $finish;
        end
    end

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // window update for one accepted sample; queues a word once the window is full
    task automatic average_sample(input in_word_t w);
        out_word_t   res;
        int unsigned ch;
        int unsigned pos;
        ch = 32'(w.channel);
        if (ch >= CHANNELS)
            return;
        if (fill_cnt[ch] < WINDOW)
        begin
            win_mem[ch][fill_cnt[ch]] = w.range_mm;
            run_sum[ch] += 32'(w.range_mm);
            fill_cnt[ch]++;
            oldest_pos[ch] = 0;
            return;
        end
        pos = oldest_pos[ch];
        run_sum[ch] = run_sum[ch] - 32'(win_mem[ch][pos]) + 32'(w.range_mm);
        win_mem[ch][pos] = w.range_mm;
        oldest_pos[ch] = (pos + 1) % WINDOW;
        res.out_channel = w.channel;
        if (w.range_mm > limit_mm[ch])
        begin
            res.out_range_mm = w.range_mm;
            res.over_range   = 1'b1;
        end
        else
        begin
            res.out_range_mm = RANGE_W'(run_sum[ch] / WINDOW);
            res.over_range   = 1'b0;
        end
        avg_expected = {avg_expected, res};
    endtask

    // driver: bursts of random length with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                average_sample(in_data);
            // a stalled word stays put
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= sample_q.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares result words and drives its own stall pattern
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin : monitor
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (avg_expected.size() == 0)
                    log_mismatch("unexpected word, range", 32'(out_data.out_range_mm), 0);
                else
                begin
                    want = avg_expected.pop_front();
                    if (out_data.out_channel !== want.out_channel)
                        log_mismatch("out_channel", 32'(out_data.out_channel),
                                     32'(want.out_channel));
                    if (out_data.out_range_mm !== want.out_range_mm)
                        log_mismatch("out_range_mm", 32'(out_data.out_range_mm),
                                     32'(want.out_range_mm));
                    if (out_data.over_range !== want.over_range)
                        log_mismatch("over_range", 32'(out_data.over_range),
                                     32'(want.over_range));
                end
            end

            // switch between free flow, light stalls and long stalls
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 250);
            end
            else
                mode_left--;

            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_sample(input logic [CH_W-1:0] ch, input logic [RANGE_W-1:0] mm);
        in_word_t w;
        w.channel  = ch;
        w.range_mm = mm;
        sample_q = {sample_q, w};
    endtask

    // random sample, biased toward the extremes and the channel's limit
    function automatic in_word_t random_sample();
        in_word_t    w;
        int          near;
        int unsigned pick;
        if ($urandom_range(0, 19) == 0)
            w.channel = 2'd3;
        else
            w.channel = CH_W'($urandom_range(0, CHANNELS - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w.range_mm = '0;
        else if (pick == 1)
            w.range_mm = RANGE_MAX;
        else if (pick <= 3 && w.channel < NUM_REGS)
        begin
            near = int'(limit_mm[w.channel]) + int'($urandom_range(0, 4)) - 2;
            if (near < 0)
                near = 0;
            if (near > 65535)
                near = 65535;
            w.range_mm = RANGE_W'(near);
        end
        else if (pick == 4)
            w.range_mm = RANGE_W'($urandom_range(0, 255));
        else
            w.range_mm = RANGE_W'($urandom());
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            limit_mm[idx] = val;
    endtask

    task automatic set_limits(input logic [RANGE_W-1:0] ch0, input logic [RANGE_W-1:0] ch1,
                              input logic [RANGE_W-1:0] ch2);
        write_reg(REG_MAX_RANGE_CH0, ch0);
        write_reg(REG_UNMAPPED, RANGE_W'($urandom()));
        write_reg(REG_MAX_RANGE_CH1, ch1);
        write_reg(REG_MAX_RANGE_CH2, ch2);
    endtask

    // all samples sent, all words back, then room for words still in flight
    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid)
            @(posedge clk);
        while (avg_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            fill_cnt[c]   = 0;
            run_sum[c]    = 0;
            oldest_pos[c] = 0;
        end
        for (int r = 0; r < NUM_REGS; r++)
            limit_mm[r] = RANGE_MAX;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale window on channel 0, then one averaged word of all ones
        for (int i = 0; i < WINDOW + 1; i++)
            queue_sample(2'd0, RANGE_MAX);
        // channel number past the last sensor is dropped
        queue_sample(2'd3, RANGE_MAX);
        queue_sample(2'd3, 16'h1234);
        // all-zero window on channel 1
        for (int i = 0; i < WINDOW + 1; i++)
            queue_sample(2'd1, '0);
        wait_drained();

        // limit boundaries: zero limit, sample equal to limit, one above
        set_limits('0, 16'd1000, RANGE_MAX);
        queue_sample(2'd0, '0);
        queue_sample(2'd0, 16'd1);
        queue_sample(2'd1, 16'd1000);
        queue_sample(2'd1, 16'd1001);
        wait_drained();

        // random phases, each under its own limit setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_limits(RANGE_W'($urandom()), RANGE_W'($urandom()),
                              RANGE_W'($urandom()));
                1: set_limits('0, '0, '0);
                2: set_limits(RANGE_MAX, RANGE_MAX, RANGE_MAX);
                3: set_limits(RANGE_W'($urandom_range(0, 4000)),
                              RANGE_W'($urandom_range(0, 4000)),
                              RANGE_W'($urandom_range(0, 4000)));
                default: set_limits(RANGE_W'($urandom_range(30000, 65535)),
                                    RANGE_W'($urandom()),
                                    RANGE_W'($urandom_range(0, 500)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                sample_q = {sample_q, random_sample()};
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("** sonar_moving_average: PASSED **");
        else
            $display("** sonar_moving_average: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sma_pkg.sv
design/sma_window.sv
design/sma_sum.sv
design/sma_div.sv
design/sma_ofifo.sv
design/sonar_moving_average.sv
tb/testbench.sv
